// ----- hdl/hswl_pkg.sv -----
// Shared constants, codes and types of the sliding-window limiter.
`default_nettype none
package hswl_pkg;

  localparam int NUM_SCOPES = 2;
  localparam int FIFO_DEPTH = 64;

  localparam int STAMP_W = 32;
  localparam int WIN_W   = 16;
  localparam int LIM_W   = 7;
  localparam int WAIT_W  = 16;
  localparam int SCNT_W  = 7;

  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int CMP_W   = (CNT_W > SCNT_W) ? CNT_W : SCNT_W;
  localparam int SIDX_W  = (NUM_SCOPES > 1) ? $clog2(NUM_SCOPES) : 1;
  localparam int RAM_DEPTH = NUM_SCOPES * FIFO_DEPTH;
  localparam int ADDR_W  = $clog2(RAM_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    REQ_CHECK   = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_CORRECT = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT0  = 2'd0,
    CFG_WINDOW0 = 2'd1,
    CFG_LIMIT1  = 2'd2,
    CFG_WINDOW1 = 2'd3
  } cfg_e;

  // result of comparing the oldest stamp against now and the window
  typedef struct packed {
    logic              evict;
    logic [WAIT_W-1:0] retry_secs;
  } age_res_t;

  function automatic logic [LIM_W-1:0] rst_limit(input int s);
    logic [LIM_W-1:0] v;
    case (s)
      0:       v = 7'd20;
      default: v = 7'd64;
    endcase
    return v;
  endfunction

  function automatic logic [WIN_W-1:0] rst_window(input int s);
    logic [WIN_W-1:0] v;
    case (s)
      0:       v = 16'd1;
      default: v = 16'd120;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/hswl_stamp_ram.sv -----
// Single-port-write, single-port-read stamp RAM with registered read data.
`default_nettype none
module hswl_stamp_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/hswl_age_calc.sv -----
// Age of the oldest stamp: eviction decision and saturated wait.
`default_nettype none
module hswl_age_calc (
  input  wire logic [hswl_pkg::STAMP_W-1:0] now_i,
  input  wire logic [hswl_pkg::STAMP_W-1:0] stamp_i,
  input  wire logic [hswl_pkg::WIN_W-1:0]   window_i,
  output hswl_pkg::age_res_t                res_o
);

  logic [hswl_pkg::STAMP_W:0]   age;
  logic [hswl_pkg::STAMP_W+1:0] remain;

  always_comb begin
    age = {1'b0, now_i} - {1'b0, stamp_i};
    // stamps from the future (negative age) are always kept
    res_o.evict = !age[hswl_pkg::STAMP_W] &&
                  (age[hswl_pkg::STAMP_W-1:0] > hswl_pkg::STAMP_W'(window_i));
    // window - age = window + stamp - now, signed
    remain = (hswl_pkg::STAMP_W+2)'(window_i) + {2'b00, stamp_i} - {2'b00, now_i};
    if (remain[hswl_pkg::STAMP_W+1]) begin
      res_o.retry_secs = '0;
    end else if (remain[hswl_pkg::STAMP_W:hswl_pkg::WAIT_W] != '0) begin
      res_o.retry_secs = '1;
    end else begin
      res_o.retry_secs = remain[hswl_pkg::WAIT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hierarchical_sliding_window_limiter.sv -----
// Top level: scope registers, operation sequencer and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | req_type, now, scope_index, server_*, new_limit
//  out     | output    | out_valid_o/out_ready_i | retry_secs, blocking_scope, blocked, overflow
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time: the beat is taken, then each scope in turn (correct: only the chosen one)
// is evicted stamp by stamp, each compare waiting on the registered stamp RAM read; check stops
// at the first blocking scope, insert then pushes one stamp per scope, correct pops or pushes the
// chosen scope to the server count, and the result is handed over. A no-operation beat skips to it.
// Reset clears FIFO heads and counts and loads limits and windows; no RAM sweep.
// A new beat is taken while the previous result waits; the hand-over stalls until it goes.
`default_nettype none
module hierarchical_sliding_window_limiter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [hswl_pkg::STAMP_W-1:0]    now_i,
  input  wire logic                            scope_index_i,
  input  wire logic [hswl_pkg::SCNT_W-1:0]     server_count_i,
  input  wire logic [hswl_pkg::LIM_W-1:0]      new_limit_i,
  input  wire logic [hswl_pkg::WIN_W-1:0]      server_window_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [hswl_pkg::WAIT_W-1:0]          retry_secs_o,
  output logic                                 blocking_scope_o,
  output logic                                 blocked_o,
  output logic                                 overflow_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [hswl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hswl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NS = hswl_pkg::NUM_SCOPES;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CMP,
    ST_PUSH,
    ST_ADJ,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  logic [hswl_pkg::PTR_W-1:0]   head_q   [NS];
  logic [hswl_pkg::PTR_W-1:0]   head_d   [NS];
  logic [hswl_pkg::CNT_W-1:0]   count_q  [NS];
  logic [hswl_pkg::CNT_W-1:0]   count_d  [NS];
  logic [hswl_pkg::LIM_W-1:0]   limit_q  [NS];
  logic [hswl_pkg::LIM_W-1:0]   limit_d  [NS];
  logic [hswl_pkg::WIN_W-1:0]   window_q [NS];
  logic [hswl_pkg::WIN_W-1:0]   window_d [NS];

  logic [hswl_pkg::SIDX_W-1:0]  cur_q, cur_d;
  logic [hswl_pkg::CMP_W-1:0]   rem_q, rem_d;

  // latched beat
  hswl_pkg::req_e               req_q, req_d;
  logic [hswl_pkg::STAMP_W-1:0] now_q, now_d;
  logic [hswl_pkg::SCNT_W-1:0]  cnt_q, cnt_d;
  logic [hswl_pkg::LIM_W-1:0]   lim_q, lim_d;
  logic [hswl_pkg::WIN_W-1:0]   win_q, win_d;

  // working result
  logic [hswl_pkg::WAIT_W-1:0]  res_wait_q, res_wait_d;
  logic                         res_who_q, res_who_d;
  logic                         res_ovf_q, res_ovf_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [hswl_pkg::WAIT_W-1:0]  out_wait_q, out_wait_d;
  logic                         out_who_q, out_who_d;
  logic                         out_ovf_q, out_ovf_d;

  logic                         ram_we, ram_re;
  logic [hswl_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr, base_addr;
  logic [hswl_pkg::STAMP_W-1:0] ram_rdata;

  hswl_pkg::age_res_t           age_res;

  logic [hswl_pkg::PTR_W:0]     slot_sum;
  logic [hswl_pkg::PTR_W-1:0]   push_slot;
  logic [hswl_pkg::PTR_W-1:0]   head_next;
  logic                         cur_full, cur_empty, cur_at_limit, cur_last;
  logic                         scope_done, scope_blk;
  logic                         cfg_scope_ok;
  logic [hswl_pkg::SIDX_W-1:0]  cfg_scope;

  hswl_stamp_ram #(
    .DATA_W (hswl_pkg::STAMP_W),
    .DEPTH  (hswl_pkg::RAM_DEPTH),
    .ADDR_W (hswl_pkg::ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (now_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hswl_age_calc u_age (
    .now_i    (now_q),
    .stamp_i  (ram_rdata),
    .window_i (window_q[cur_q]),
    .res_o    (age_res)
  );

  always_comb begin
    base_addr = hswl_pkg::ADDR_W'(cur_q) * hswl_pkg::ADDR_W'(hswl_pkg::FIFO_DEPTH);
    ram_raddr = base_addr + hswl_pkg::ADDR_W'(head_q[cur_q]);
    slot_sum  = (hswl_pkg::PTR_W+1)'(head_q[cur_q]) + (hswl_pkg::PTR_W+1)'(count_q[cur_q]);
    if (slot_sum >= (hswl_pkg::PTR_W+1)'(hswl_pkg::FIFO_DEPTH)) begin
      push_slot = hswl_pkg::PTR_W'(slot_sum - (hswl_pkg::PTR_W+1)'(hswl_pkg::FIFO_DEPTH));
    end else begin
      push_slot = hswl_pkg::PTR_W'(slot_sum);
    end
    ram_waddr = base_addr + hswl_pkg::ADDR_W'(push_slot);
    head_next = (head_q[cur_q] == hswl_pkg::PTR_W'(hswl_pkg::FIFO_DEPTH - 1)) ?
                '0 : head_q[cur_q] + 1'b1;
    cur_full     = (count_q[cur_q] == hswl_pkg::CNT_W'(hswl_pkg::FIFO_DEPTH));
    cur_empty    = (count_q[cur_q] == '0);
    cur_at_limit = (hswl_pkg::CMP_W'(count_q[cur_q]) >= hswl_pkg::CMP_W'(limit_q[cur_q]));
    cur_last     = (cur_q == hswl_pkg::SIDX_W'(NS - 1));
    scope_done   = ((state_q == ST_EV_RD) && cur_empty) ||
                   ((state_q == ST_EV_CMP) && !age_res.evict);
    scope_blk    = (state_q == ST_EV_CMP) && (req_q == hswl_pkg::REQ_CHECK) &&
                   cur_at_limit && (age_res.retry_secs != '0);
    cfg_scope    = hswl_pkg::SIDX_W'(cfg_index_i[1]);
    cfg_scope_ok = (32'(cfg_index_i[1]) < NS);
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    limit_d    = limit_q;
    window_d   = window_q;
    cur_d      = cur_q;
    rem_d      = rem_q;
    req_d      = req_q;
    now_d      = now_q;
    cnt_d      = cnt_q;
    lim_d      = lim_q;
    win_d      = win_q;
    res_wait_d = res_wait_q;
    res_who_d  = res_who_q;
    res_ovf_d  = res_ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_wait_d = out_wait_q;
    out_who_d  = out_who_q;
    out_ovf_d  = out_ovf_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = hswl_pkg::req_e'(req_type_i);
          now_d      = now_i;
          cnt_d      = server_count_i;
          lim_d      = new_limit_i;
          win_d      = server_window_i;
          res_wait_d = '0;
          res_who_d  = 1'b0;
          res_ovf_d  = 1'b0;
          cur_d      = '0;
          case (hswl_pkg::req_e'(req_type_i))
            hswl_pkg::REQ_CHECK, hswl_pkg::REQ_INSERT: state_d = ST_EV_RD;
            hswl_pkg::REQ_CORRECT: begin
              if (32'(scope_index_i) < NS) begin
                cur_d   = hswl_pkg::SIDX_W'(scope_index_i);
                state_d = ST_EV_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_EV_RD: begin
        if (!cur_empty) begin
          ram_re  = 1'b1;
          state_d = ST_EV_CMP;
        end
      end
      ST_EV_CMP: begin
        if (age_res.evict) begin
          head_d[cur_q]  = head_next;
          count_d[cur_q] = count_q[cur_q] - 1'b1;
          state_d        = ST_EV_RD;
        end
      end
      ST_PUSH: begin
        if (cur_full) begin
          res_ovf_d = 1'b1;
        end else begin
          ram_we         = 1'b1;
          count_d[cur_q] = count_q[cur_q] + 1'b1;
        end
        if (cur_last) begin
          state_d = ST_DONE;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      ST_ADJ: begin
        if (hswl_pkg::CMP_W'(count_q[cur_q]) > hswl_pkg::CMP_W'(cnt_q)) begin
          head_d[cur_q]  = head_next;
          count_d[cur_q] = count_q[cur_q] - 1'b1;
        end else begin
          rem_d   = hswl_pkg::CMP_W'(cnt_q) - hswl_pkg::CMP_W'(count_q[cur_q]);
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (rem_q == '0) begin
          state_d = ST_DONE;
        end else begin
          // a dropped copy still counts towards the server figure
          rem_d = rem_q - 1'b1;
          if (cur_full) begin
            res_ovf_d = 1'b1;
          end else begin
            ram_we         = 1'b1;
            count_d[cur_q] = count_q[cur_q] + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_wait_d  = res_wait_q;
          out_who_d   = res_who_q;
          out_ovf_d   = res_ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // scope finished evicting: move on according to the operation
    if (scope_done) begin
      case (req_q)
        hswl_pkg::REQ_CHECK: begin
          if (scope_blk) begin
            res_wait_d = age_res.retry_secs;
            res_who_d  = 1'(cur_q);
            state_d    = ST_DONE;
          end else if (cur_last) begin
            state_d = ST_DONE;
          end else begin
            cur_d   = cur_q + 1'b1;
            state_d = ST_EV_RD;
          end
        end
        hswl_pkg::REQ_INSERT: begin
          if (cur_last) begin
            cur_d   = '0;
            state_d = ST_PUSH;
          end else begin
            cur_d   = cur_q + 1'b1;
            state_d = ST_EV_RD;
          end
        end
        hswl_pkg::REQ_CORRECT: begin
          limit_d[cur_q]  = lim_q;
          window_d[cur_q] = win_q;
          state_d         = ST_ADJ;
        end
        default: state_d = ST_DONE;
      endcase
    end

    if (cfg_valid_i && cfg_scope_ok) begin
      case (hswl_pkg::cfg_e'(cfg_index_i))
        hswl_pkg::CFG_LIMIT0, hswl_pkg::CFG_LIMIT1:
          limit_d[cfg_scope] = cfg_data_i[hswl_pkg::LIM_W-1:0];
        hswl_pkg::CFG_WINDOW0, hswl_pkg::CFG_WINDOW1:
          window_d[cfg_scope] = cfg_data_i[hswl_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < NS; s++) begin
        head_q[s]   <= '0;
        count_q[s]  <= '0;
        limit_q[s]  <= hswl_pkg::rst_limit(s);
        window_q[s] <= hswl_pkg::rst_window(s);
      end
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      count_q     <= count_d;
      limit_q     <= limit_d;
      window_q    <= window_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    req_q      <= req_d;
    now_q      <= now_d;
    cnt_q      <= cnt_d;
    lim_q      <= lim_d;
    win_q      <= win_d;
    res_wait_q <= res_wait_d;
    res_who_q  <= res_who_d;
    res_ovf_q  <= res_ovf_d;
    out_wait_q <= out_wait_d;
    out_who_q  <= out_who_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign retry_secs_o     = out_wait_q;
  assign blocking_scope_o = out_who_q;
  assign blocked_o        = (out_wait_q != '0);
  assign overflow_o       = out_ovf_q;

endmodule
`default_nettype wire

// ----- verif/hierarchical_sliding_window_limiter_checker.sv -----
// Scoreboard for the sliding-window limiter: predicts every result beat and compares it.
`timescale 1ns / 100ps
module hierarchical_sliding_window_limiter_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [hswl_pkg::STAMP_W-1:0]    now_i,
  input  wire logic                            scope_index_i,
  input  wire logic [hswl_pkg::SCNT_W-1:0]     server_count_i,
  input  wire logic [hswl_pkg::LIM_W-1:0]      new_limit_i,
  input  wire logic [hswl_pkg::WIN_W-1:0]      server_window_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic [hswl_pkg::WAIT_W-1:0]     retry_secs_i,
  input  wire logic                            blocking_scope_i,
  input  wire logic                            blocked_i,
  input  wire logic                            overflow_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_i,
  input  wire logic [hswl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hswl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                   pending_o,
  output int                                   mismatches_o
);

  typedef struct {
    logic [hswl_pkg::WAIT_W-1:0] retry_secs;
    logic                        blocking_scope;
    logic                        blocked;
    logic                        overflow;
  } verdict_t;

  // shadow of the limiter state
  logic [hswl_pkg::STAMP_W-1:0] stamps   [hswl_pkg::NUM_SCOPES][hswl_pkg::FIFO_DEPTH];
  logic [hswl_pkg::PTR_W-1:0]   head     [hswl_pkg::NUM_SCOPES];
  logic [hswl_pkg::CNT_W-1:0]   fill     [hswl_pkg::NUM_SCOPES];
  logic [hswl_pkg::LIM_W-1:0]   lim_live [hswl_pkg::NUM_SCOPES];
  logic [hswl_pkg::WIN_W-1:0]   win_live [hswl_pkg::NUM_SCOPES];

  verdict_t verdict_q [$];
  verdict_t want;
  int       fail_tally = 0;

  assign mismatches_o = fail_tally;

  function automatic longint age_of_head(int s, logic [hswl_pkg::STAMP_W-1:0] now);
    longint a;
    longint b;
    a = longint'(now);
    b = longint'(stamps[s][head[s]]);
    return a - b;
  endfunction

  function automatic void retire_head(int s);
    if (fill[s] == '0) return;
    head[s] = (head[s] == hswl_pkg::FIFO_DEPTH - 1) ? '0 : head[s] + 1'b1;
    fill[s] = fill[s] - 1'b1;
  endfunction

  function automatic bit append_stamp(int s, logic [hswl_pkg::STAMP_W-1:0] t);
    int slot;
    if (fill[s] >= hswl_pkg::FIFO_DEPTH) return 1'b0;
    slot = (int'(head[s]) + int'(fill[s])) % hswl_pkg::FIFO_DEPTH;
    stamps[s][slot] = t;
    fill[s] = fill[s] + 1'b1;
    return 1'b1;
  endfunction

  // strict greater-than: a stamp exactly one window old survives
  function automatic void trim_window(int s, logic [hswl_pkg::STAMP_W-1:0] now);
    longint span;
    span = longint'(win_live[s]);
    while (fill[s] != '0 && age_of_head(s, now) > span) retire_head(s);
  endfunction

  function automatic logic [hswl_pkg::WAIT_W-1:0] hold_time(int s,
                                                           logic [hswl_pkg::STAMP_W-1:0] now);
    longint span;
    longint w;
    trim_window(s, now);
    if (fill[s] == '0 || fill[s] < lim_live[s]) return '0;
    span = longint'(win_live[s]);
    w = span - age_of_head(s, now);
    if (w < 0) return '0;
    if (w > 65535) return '1;
    return w[hswl_pkg::WAIT_W-1:0];
  endfunction

  function automatic verdict_t predict_verdict(
    hswl_pkg::req_e op, logic [hswl_pkg::STAMP_W-1:0] now, logic idx,
    logic [hswl_pkg::SCNT_W-1:0] cnt, logic [hswl_pkg::LIM_W-1:0] lim,
    logic [hswl_pkg::WIN_W-1:0] win);
    verdict_t v;
    int s;
    int have;
    v = '{default: '0};
    case (op)
      hswl_pkg::REQ_CHECK: begin
        for (s = 0; s < hswl_pkg::NUM_SCOPES; s++) begin
          v.retry_secs = hold_time(s, now);
          if (v.retry_secs != '0) begin
            v.blocking_scope = 1'(s);
            break;
          end
        end
        v.blocked = (v.retry_secs != '0);
      end
      hswl_pkg::REQ_INSERT: begin
        for (s = 0; s < hswl_pkg::NUM_SCOPES; s++) trim_window(s, now);
        for (s = 0; s < hswl_pkg::NUM_SCOPES; s++)
          if (!append_stamp(s, now)) v.overflow = 1'b1;
      end
      hswl_pkg::REQ_CORRECT: begin
        s = int'(idx);
        if (s < hswl_pkg::NUM_SCOPES) begin
          // eviction still sees the old window
          trim_window(s, now);
          lim_live[s] = lim;
          win_live[s] = win;
          while (fill[s] > cnt) retire_head(s);
          have = int'(fill[s]);
          while (have < int'(cnt)) begin
            if (!append_stamp(s, now)) v.overflow = 1'b1;
            have++;
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic void check_field(string field, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, actual %0d", field, exp_v, got_v);
      fail_tally++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q.delete();
      for (int s = 0; s < hswl_pkg::NUM_SCOPES; s++) begin
        head[s] = '0;
        fill[s] = '0;
      end
      lim_live[0] = 7'd20;
      win_live[0] = 16'd1;
      lim_live[1] = 7'd64;
      win_live[1] = 16'd120;
      pending_o <= 0;
    end else begin
      // register writes must land only while idle (the limiter does not enforce it); then their order here is moot
      if (cfg_valid_i && cfg_ready_i) begin
        case (hswl_pkg::cfg_e'(cfg_index_i))
          hswl_pkg::CFG_LIMIT0:  lim_live[0] = cfg_data_i[hswl_pkg::LIM_W-1:0];
          hswl_pkg::CFG_WINDOW0: win_live[0] = cfg_data_i[hswl_pkg::WIN_W-1:0];
          hswl_pkg::CFG_LIMIT1:  lim_live[1] = cfg_data_i[hswl_pkg::LIM_W-1:0];
          hswl_pkg::CFG_WINDOW1: win_live[1] = cfg_data_i[hswl_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_tally++;
        end else begin
          want = verdict_q.pop_front();
          check_field("retry_secs", want.retry_secs, retry_secs_i);
          check_field("blocking_scope", want.blocking_scope, blocking_scope_i);
          check_field("blocked", want.blocked, blocked_i);
          check_field("overflow", want.overflow, overflow_i);
        end
      end
      if (in_valid_i && in_ready_i)
        verdict_q.insert(verdict_q.size(),
                         predict_verdict(hswl_pkg::req_e'(req_type_i), now_i, scope_index_i,
                                         server_count_i, new_limit_i, server_window_i));
      pending_o <= verdict_q.size();
    end
  end

endmodule

// ----- verif/hierarchical_sliding_window_limiter_tb.sv -----
// Testbench top for the sliding-window limiter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module hierarchical_sliding_window_limiter_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 400;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 250;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      req_type = '0;
  logic [hswl_pkg::STAMP_W-1:0]    now = '0;
  logic                            scope_index = 1'b0;
  logic [hswl_pkg::SCNT_W-1:0]     server_count = '0;
  logic [hswl_pkg::LIM_W-1:0]      new_limit = '0;
  logic [hswl_pkg::WIN_W-1:0]      server_window = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [hswl_pkg::WAIT_W-1:0]     retry_secs;
  logic                            blocking_scope;
  logic                            blocked;
  logic                            overflow;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [hswl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hswl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int   pending;
  int   mismatches;
  int   send_idle = 0;
  int   recv_idle = 0;
  logic squeeze = 1'b0;
  logic hold_off = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hierarchical_sliding_window_limiter uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .req_type_i      (req_type),
    .now_i           (now),
    .scope_index_i   (scope_index),
    .server_count_i  (server_count),
    .new_limit_i     (new_limit),
    .server_window_i (server_window),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .retry_secs_o    (retry_secs),
    .blocking_scope_o(blocking_scope),
    .blocked_o       (blocked),
    .overflow_o      (overflow),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  hierarchical_sliding_window_limiter_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .req_type_i      (req_type),
    .now_i           (now),
    .scope_index_i   (scope_index),
    .server_count_i  (server_count),
    .new_limit_i     (new_limit),
    .server_window_i (server_window),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .retry_secs_i    (retry_secs),
    .blocking_scope_i(blocking_scope),
    .blocked_i       (blocked),
    .overflow_i      (overflow),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .mismatches_o    (mismatches)
  );

  // result side: random back-pressure, plus one long hold-off
  always @(posedge clk) out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);

  initial begin
    wait (squeeze);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // present one request beat and hold it until taken
  task automatic offer(hswl_pkg::req_e op, logic [hswl_pkg::STAMP_W-1:0] t, logic idx,
                       logic [hswl_pkg::SCNT_W-1:0] cnt, logic [hswl_pkg::LIM_W-1:0] lim,
                       logic [hswl_pkg::WIN_W-1:0] win);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= op;
    now           <= t;
    scope_index   <= idx;
    server_count  <= cnt;
    new_limit     <= lim;
    server_window <= win;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // valid stays high across the four beats
  task automatic program_regs(logic [hswl_pkg::CFG_DATA_W-1:0] vals [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= hswl_pkg::cfg_e'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [hswl_pkg::CFG_DATA_W-1:0] regs [4];
    logic [hswl_pkg::STAMP_W-1:0]    t_now;
    int                              r;
    hswl_pkg::req_e                  op;
    logic [hswl_pkg::SCNT_W-1:0]     cnt;
    logic [hswl_pkg::LIM_W-1:0]      lim;
    logic [hswl_pkg::WIN_W-1:0]      win;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits and windows first
    offer(hswl_pkg::REQ_CHECK,   32'd0, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_NOP,     32'hFFFF_FFFF, 1'b1, 7'h7F, 7'h7F, 16'hFFFF);
    offer(hswl_pkg::REQ_CORRECT, 32'd100, 1'b0, 7'd20, 7'd3, 16'd10);
    offer(hswl_pkg::REQ_CHECK,   32'd102, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CORRECT, 32'd100, 1'b1, 7'd127, 7'd64, 16'd120);  // pushes past full
    offer(hswl_pkg::REQ_INSERT,  32'd103, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CHECK,   32'd104, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CORRECT, 32'd104, 1'b0, 7'd0, 7'd5, 16'd0);
    offer(hswl_pkg::REQ_CHECK,   32'd104, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CORRECT, 32'd200, 1'b1, 7'd64, 7'd1, 16'hFFFF);
    offer(hswl_pkg::REQ_CHECK,   32'd0, 1'b0, 7'd0, 7'd0, 16'd0);     // time backwards, saturates
    offer(hswl_pkg::REQ_CORRECT, 32'd1000, 1'b0, 7'd2, 7'd2, 16'd5);
    offer(hswl_pkg::REQ_CHECK,   32'd1005, 1'b0, 7'd0, 7'd0, 16'd0);  // zero wait, moves on
    offer(hswl_pkg::REQ_CORRECT, 32'd1005, 1'b0, 7'd0, 7'd0, 16'd0);  // empty with zero limit
    offer(hswl_pkg::REQ_CHECK,   32'd1005, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_INSERT,  32'd1006, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CORRECT, 32'd2000, 1'b0, 7'd1, 7'd1, 16'd3);
    offer(hswl_pkg::REQ_CHECK,   32'd2002, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CHECK,   32'd2003, 1'b0, 7'd0, 7'd0, 16'd0);  // exactly one window old
    offer(hswl_pkg::REQ_CORRECT, 32'd2004, 1'b1, 7'd5, 7'd5, 16'd10);
    offer(hswl_pkg::REQ_INSERT,  32'hFFFF_FFFF, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CHECK,   32'hFFFF_FFFF, 1'b0, 7'd0, 7'd0, 16'd0);
    drain();

    regs[hswl_pkg::CFG_LIMIT0]  = 16'd1;
    regs[hswl_pkg::CFG_WINDOW0] = 16'd0;
    regs[hswl_pkg::CFG_LIMIT1]  = 16'd127;
    regs[hswl_pkg::CFG_WINDOW1] = 16'hFFFF;
    program_regs(regs);
    offer(hswl_pkg::REQ_INSERT,  32'd5, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CHECK,   32'd4, 1'b0, 7'd0, 7'd0, 16'd0);
    offer(hswl_pkg::REQ_CHECK,   32'd5, 1'b0, 7'd0, 7'd0, 16'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      send_idle = (p < 2) ? 36 : (p < 4) ? 80 : 0;
      recv_idle <= (p < 2) ? 80 : (p < 4) ? 36 : 0;
      for (int i = 0; i < 4; i++) begin
        r = $urandom_range(99);
        if (i == hswl_pkg::CFG_LIMIT0 || i == hswl_pkg::CFG_LIMIT1)
          regs[i] = (r < 70) ? 16'($urandom_range(8, 1)) :
                    (r < 80) ? 16'd64 :
                    (r < 90) ? 16'($urandom) : 16'($urandom_range(127, 0));
        else
          regs[i] = (r < 75) ? 16'($urandom_range(20, 0)) :
                    (r < 85) ? 16'($urandom) :
                    (r < 92) ? 16'hFFFF : 16'd0;
      end
      program_regs(regs);
      t_now = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == PHASES - 1 && k == 40) squeeze <= 1'b1;
        cnt = 7'($urandom);
        lim = 7'($urandom);
        win = 16'($urandom);
        if ($urandom_range(99) < 80) begin
          // steady clock with small steps so the windows fill and block
          r = $urandom_range(99);
          t_now += (r < 90) ? $urandom_range(3, 0) :
                   (r < 97) ? $urandom_range(40, 0) : $urandom;
          r = $urandom_range(99);
          op = (r < 45) ? hswl_pkg::REQ_INSERT :
               (r < 85) ? hswl_pkg::REQ_CHECK : hswl_pkg::REQ_CORRECT;
          if (op == hswl_pkg::REQ_CORRECT) begin
            cnt = ($urandom_range(9) != 0) ? 7'($urandom_range(10, 0)) :
                                             7'($urandom_range(127, 0));
            lim = ($urandom_range(9) != 0) ? 7'($urandom_range(10, 1)) :
                                             7'($urandom_range(127, 0));
            win = ($urandom_range(9) != 0) ? 16'($urandom_range(20, 0)) : 16'($urandom);
          end
          offer(op, t_now, 1'($urandom), cnt, lim, win);
        end else begin
          offer(hswl_pkg::req_e'($urandom_range(3, 0)), $urandom, 1'($urandom), cnt, lim, win);
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
